// File: sv/frrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frrt_pkg: shared types of the fragment range reassembly tracker
// Holds the request and result beat layouts, the operation and status codes,
// the commit modes broadcast to the range cells and the probe token flags.
// ----------------------------------------------------------------------------
package frrt_pkg;

  // Operation codes of a request beat.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Status codes of a result beat.
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_INVALID  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVERLAP  = 3'd4,
    ST_FULL     = 3'd5,
    ST_CLEARED  = 3'd6
  } frrt_status_e;

  // How the cells rewrite the table when a fragment is accepted.
  typedef enum logic [2:0] {
    CM_HOLD       = 3'd0,
    CM_INSERT     = 3'd1,
    CM_MERGE_PREV = 3'd2,
    CM_MERGE_NEXT = 3'd3,
    CM_MERGE_BOTH = 3'd4
  } frrt_commit_e;

  // Request beat.
  typedef struct packed {
    logic        operation;
    logic [23:0] frag_offset;
    logic [23:0] frag_length;
    logic [23:0] message_length;
  } frrt_req_t;

  // Result beat.
  typedef struct packed {
    frrt_status_e status;
    logic         complete;
    logic [3:0]   range_count;
    logic [23:0]  bytes_received;
    logic [3:0]   hole_count;
  } frrt_rsp_t;

  // Flags that the probe token collects as it walks the cell chain.
  typedef struct packed {
    logic vld;   // token present in this stage
    logic hit;   // an overlapping range was found
    logic dup;   // the first overlapping range has equal bounds
    logic mp;    // fragment touches the range before its slot
    logic mn;    // fragment touches the range after its slot
    logic seen;  // the first range starting after the fragment was passed
  } frrt_tok_t;

endpackage

// File: sv/frrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frrt_cell: one entry of the range table
// Holds one range, checks the passing probe token against it and hands the
// token to the next cell. On a commit it rewrites itself from its own value,
// a neighbor's value or the fragment, which shifts or merges the table.
// ----------------------------------------------------------------------------
module frrt_cell
  import frrt_pkg::*;
#(
  parameter int unsigned IDX         = 0,
  parameter int unsigned LENGTH_BITS = 24,
  parameter int unsigned POS_W       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [LENGTH_BITS-1:0] probe_off_i,
  input  logic [LENGTH_BITS:0]   probe_fin_i,
  input  logic [POS_W-1:0]       held_i,
  input  frrt_tok_t              tok_i,
  input  logic [POS_W-1:0]       tok_pos_i,
  output frrt_tok_t              tok_o,
  output logic [POS_W-1:0]       tok_pos_o,
  input  frrt_commit_e           commit_i,
  input  logic [POS_W-1:0]       ins_pos_i,
  input  logic [LENGTH_BITS-1:0] left_beg_i,
  input  logic [LENGTH_BITS-1:0] left_fin_i,
  input  logic [LENGTH_BITS-1:0] right_beg_i,
  input  logic [LENGTH_BITS-1:0] right_fin_i,
  output logic [LENGTH_BITS-1:0] beg_o,
  output logic [LENGTH_BITS-1:0] fin_o
);

  localparam logic [POS_W-1:0] MY_POS   = POS_W'(IDX);
  localparam logic [POS_W-1:0] NEXT_POS = POS_W'(IDX + 1);

  logic [LENGTH_BITS-1:0] beg_q, beg_d;
  logic [LENGTH_BITS-1:0] fin_q, fin_d;
  frrt_tok_t              tok_q, tok_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic                   occupied;
  logic                   ov, eq, le;
  logic [LENGTH_BITS-1:0] probe_fin_l;

  assign occupied    = MY_POS < held_i;
  assign probe_fin_l = probe_fin_i[LENGTH_BITS-1:0];

  // Relation of the fragment to the range held here.
  assign ov = ({1'b0, probe_off_i} < {1'b0, fin_q}) && (probe_fin_i > {1'b0, beg_q});
  assign eq = (probe_off_i == beg_q) && (probe_fin_i == {1'b0, fin_q});
  assign le = beg_q <= probe_off_i;

  // Token update: first overlap decides, slot and touch flags follow order.
  always_comb begin
    tok_d = tok_i;
    pos_d = tok_pos_i;
    if (tok_i.vld && occupied) begin
      if (!tok_i.hit && ov) begin
        tok_d.hit = 1'b1;
        tok_d.dup = eq;
      end
      if (le) begin
        pos_d    = NEXT_POS;
        tok_d.mp = {1'b0, probe_off_i} <= {1'b0, fin_q};
      end else if (!tok_i.seen) begin
        tok_d.seen = 1'b1;
        tok_d.mn   = probe_fin_i >= {1'b0, beg_q};
      end
    end
  end

  // Token stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      pos_q <= '0;
    end else begin
      tok_q <= tok_d;
      pos_q <= pos_d;
    end
  end

  // Table rewrite on commit.
  always_comb begin
    beg_d = beg_q;
    fin_d = fin_q;
    unique case (commit_i)
      CM_HOLD: begin
      end
      CM_INSERT: begin
        if (MY_POS == ins_pos_i) begin
          beg_d = probe_off_i;
          fin_d = probe_fin_l;
        end else if (MY_POS > ins_pos_i) begin
          beg_d = left_beg_i;
          fin_d = left_fin_i;
        end
      end
      CM_MERGE_PREV: begin
        if (NEXT_POS == ins_pos_i && probe_fin_l > fin_q) begin
          fin_d = probe_fin_l;
        end
      end
      CM_MERGE_NEXT: begin
        if (MY_POS == ins_pos_i) begin
          beg_d = probe_off_i;
        end
      end
      CM_MERGE_BOTH: begin
        if (NEXT_POS == ins_pos_i) begin
          fin_d = right_fin_i;
        end else if (MY_POS > ins_pos_i || MY_POS == ins_pos_i) begin
          beg_d = right_beg_i;
          fin_d = right_fin_i;
        end
      end
      default: begin
      end
    endcase
  end

  // Range storage.
  always_ff @(posedge clk_i) begin
    beg_q <= beg_d;
    fin_q <= fin_d;
  end

  assign tok_o     = tok_q;
  assign tok_pos_o = pos_q;
  assign beg_o     = beg_q;
  assign fin_o     = fin_q;

endmodule

// File: sv/fragment_range_reassembly_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_range_reassembly_tracker: byte range tracker for one message
// Keeps the sorted, merged byte ranges of a fragmented message in a chain of
// range cells and reports coverage after every add or clear request.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. An add request
// holds busy while a probe token walks the chain of range cells one cell per
// cycle; the table is rewritten as the token leaves the last cell, and the
// result is built after that. A clear request holds busy only while its result
// is built. The result beat sits on rsp_o for exactly one cycle with done_o high,
// in the cycle right after busy falls; the receiver cannot stall it, and a new
// request may be started in that same cycle.
module fragment_range_reassembly_tracker
  import frrt_pkg::*;
#(
  parameter int unsigned MAX_RANGES  = 8,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  frrt_req_t req_i,
  output logic      busy,
  output logic      done_o,
  output frrt_rsp_t rsp_o
);

  localparam int unsigned POS_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned GAP_W = $clog2(MAX_RANGES + 2);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_RANGES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]             state_q, state_d;
  logic                   launch_q;
  logic [LENGTH_BITS-1:0] off_q, len_q, tot_q;
  logic [LENGTH_BITS:0]   fin_q;
  logic [POS_W-1:0]       held_q, held_d;
  logic [LENGTH_BITS-1:0] total_q, total_d;
  logic [LENGTH_BITS-1:0] bytes_q, bytes_d;
  frrt_status_e           status_q, status_d;
  logic                   done_q;
  frrt_rsp_t              rsp_q, rsp_d;
  logic                   accept;

  frrt_tok_t              tok   [MAX_RANGES+1];
  logic [POS_W-1:0]       pos   [MAX_RANGES+1];
  logic [MAX_RANGES:0]    tok_vld_vec;
  logic [LENGTH_BITS-1:0] beg   [MAX_RANGES];
  logic [LENGTH_BITS-1:0] fin   [MAX_RANGES];
  logic [LENGTH_BITS-1:0] lbeg  [MAX_RANGES];
  logic [LENGTH_BITS-1:0] lfin  [MAX_RANGES];
  logic [LENGTH_BITS-1:0] rbeg  [MAX_RANGES];
  logic [LENGTH_BITS-1:0] rfin  [MAX_RANGES];
  frrt_commit_e           commit;
  frrt_commit_e           mode;
  frrt_status_e           verdict;
  logic [LENGTH_BITS-1:0] last_fin;
  logic [GAP_W-1:0]       gaps;

  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;

  // Probe token enters the first cell in the cycle after the request is taken.
  assign tok[0] = '{vld: launch_q, default: 1'b0};
  assign pos[0] = '0;

  // Cell chain with neighbor taps.
  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lbeg[g] = '0;
      assign lfin[g] = '0;
    end else begin : g_left
      assign lbeg[g] = beg[g-1];
      assign lfin[g] = fin[g-1];
    end
    if (g == MAX_RANGES - 1) begin : g_last
      assign rbeg[g] = '0;
      assign rfin[g] = '0;
    end else begin : g_right
      assign rbeg[g] = beg[g+1];
      assign rfin[g] = fin[g+1];
    end

    frrt_cell #(
      .IDX        (g),
      .LENGTH_BITS(LENGTH_BITS),
      .POS_W      (POS_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .probe_off_i(off_q),
      .probe_fin_i(fin_q),
      .held_i     (held_q),
      .tok_i      (tok[g]),
      .tok_pos_i  (pos[g]),
      .tok_o      (tok[g+1]),
      .tok_pos_o  (pos[g+1]),
      .commit_i   (commit),
      .ins_pos_i  (pos[MAX_RANGES]),
      .left_beg_i (lbeg[g]),
      .left_fin_i (lfin[g]),
      .right_beg_i(rbeg[g]),
      .right_fin_i(rfin[g]),
      .beg_o      (beg[g]),
      .fin_o      (fin[g])
    );
  end

  for (genvar k = 0; k <= MAX_RANGES; k++) begin : g_vld
    assign tok_vld_vec[k] = tok[k].vld;
  end

  // Verdict once the token leaves the last cell.
  always_comb begin
    if (tok[MAX_RANGES].mp && tok[MAX_RANGES].mn) begin
      mode = CM_MERGE_BOTH;
    end else if (tok[MAX_RANGES].mp) begin
      mode = CM_MERGE_PREV;
    end else if (tok[MAX_RANGES].mn) begin
      mode = CM_MERGE_NEXT;
    end else begin
      mode = CM_INSERT;
    end

    priority if (fin_q > {1'b0, tot_q}) begin
      verdict = ST_INVALID;
    end else if (held_q != '0 && tot_q != total_q) begin
      verdict = ST_MISMATCH;
    end else if (tok[MAX_RANGES].hit) begin
      verdict = tok[MAX_RANGES].dup ? ST_DUP : ST_OVERLAP;
    end else if (mode == CM_INSERT && held_q == MAX_POS) begin
      verdict = ST_FULL;
    end else begin
      verdict = ST_ADDED;
    end
  end

  assign commit = (state_q == S_WALK && tok[MAX_RANGES].vld && verdict == ST_ADDED)
                  ? mode : CM_HOLD;

  // End of the last held range.
  always_comb begin
    last_fin = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (held_q == POS_W'(i + 1)) begin
        last_fin = last_fin | fin[i];
      end
    end
  end

  // Coverage report: ranges are strictly apart, so every range after the
  // first opens a hole of its own.
  always_comb begin
    gaps = '0;
    if (held_q != '0) begin
      gaps = GAP_W'(held_q - POS_W'(1)) + GAP_W'(beg[0] != '0)
           + GAP_W'(last_fin < total_q);
    end
    rsp_d.status         = status_q;
    rsp_d.complete       = (held_q == POS_W'(1)) && (total_q != '0) && (beg[0] == '0)
                           && (fin[0] == total_q);
    rsp_d.range_count    = 4'(held_q);
    rsp_d.bytes_received = 24'(bytes_q);
    rsp_d.hole_count     = 4'(gaps);
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    total_d  = total_q;
    bytes_d  = bytes_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.operation == OP_CLEAR) begin
            held_d   = '0;
            total_d  = '0;
            bytes_d  = '0;
            status_d = ST_CLEARED;
            state_d  = S_RESP;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (tok[MAX_RANGES].vld) begin
          status_d = verdict;
          if (verdict == ST_ADDED) begin
            total_d = tot_q;
            bytes_d = bytes_q + len_q;
            if (mode == CM_INSERT) begin
              held_d = held_q + POS_W'(1);
            end else if (mode == CM_MERGE_BOTH) begin
              held_d = held_q - POS_W'(1);
            end
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      held_q   <= '0;
      total_q  <= '0;
      bytes_q  <= '0;
      status_q <= ST_ADDED;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept && (req_i.operation == OP_ADD);
      held_q   <= held_d;
      total_q  <= total_d;
      bytes_q  <= bytes_d;
      status_q <= status_d;
      done_q   <= state_q == S_RESP;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      off_q <= LENGTH_BITS'(req_i.frag_offset);
      len_q <= LENGTH_BITS'(req_i.frag_length);
      tot_q <= LENGTH_BITS'(req_i.message_length);
      fin_q <= {1'b0, LENGTH_BITS'(req_i.frag_offset)}
             + {1'b0, LENGTH_BITS'(req_i.frag_length)};
    end
    if (state_q == S_RESP) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // At most one probe token is in flight along the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld_vec))
    else $error("more than one probe token in the cell chain");

  // The table never holds more ranges than it has cells.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= MAX_POS)
    else $error("range count beyond table size");

  // A token leaving the chain always leads to the result cycle.
  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && tok[MAX_RANGES].vld) |=> (state_q == S_RESP))
    else $error("probe token left the chain without a verdict");

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");
`endif

endmodule
